>>> design/aes_pkg.sv
// Package for the AES ECB/CBC block: types, S-box tables, round helpers.
// No dependencies; used by aes_block_cipher_ecb_cbc and its testbench.
package aes_pkg;

  localparam int unsigned MaxRounds = 14;
  localparam int unsigned RkWords   = 4 * (MaxRounds + 1);
  localparam int unsigned RkAw      = $clog2(RkWords);
  localparam int unsigned RndW      = $clog2(MaxRounds + 1);

  localparam logic [2:0] CfgKey0  = 3'd0;
  localparam logic [2:0] CfgKey1  = 3'd1;
  localparam logic [2:0] CfgKey2  = 3'd2;
  localparam logic [2:0] CfgKey3  = 3'd3;
  localparam logic [2:0] CfgIvHi  = 3'd4;
  localparam logic [2:0] CfgIvLo  = 3'd5;
  localparam logic [2:0] CfgKsize = 3'd6;
  localparam logic [2:0] CfgChain = 3'd7;

  localparam logic [1:0] Ksize192 = 2'd1;
  localparam logic [1:0] Ksize256 = 2'd2;

  typedef logic [7:0] byte_t;
  typedef logic [127:0] blk_t;

  function automatic byte_t fwd_sbox(input byte_t a);
    byte_t r;
    unique case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // The inverse table is derived from the forward one by search.
  function automatic byte_t inv_sbox(input byte_t a);
    byte_t r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (fwd_sbox(byte_t'(i)) == a) r = byte_t'(i);
    end
    return r;
  endfunction

  function automatic byte_t xtime(input byte_t b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {fwd_sbox(w[31:24]), fwd_sbox(w[23:16]), fwd_sbox(w[15:8]), fwd_sbox(w[7:0])};
  endfunction

  // Byte k of the block (k = 4*col + row) sits at bits 127-8k.
  function automatic byte_t gb(input blk_t s, input int k);
    return s[127-8*k -: 8];
  endfunction

  function automatic blk_t sub_shift(input blk_t s, input logic inv);
    blk_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) t[127-8*(4*((c+r)%4)+r) -: 8] = inv_sbox(gb(s, 4*c+r));
        else     t[127-8*(4*c+r) -: 8] = fwd_sbox(gb(s, 4*((c+r)%4)+r));
      end
    end
    return t;
  endfunction

  function automatic blk_t mix(input blk_t s, input logic inv);
    blk_t t;
    byte_t a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = gb(s, 4*c); a1 = gb(s, 4*c+1); a2 = gb(s, 4*c+2); a3 = gb(s, 4*c+3);
      x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
      y0 = xtime(x0); y1 = xtime(x1); y2 = xtime(x2); y3 = xtime(x3);
      z0 = xtime(y0); z1 = xtime(y1); z2 = xtime(y2); z3 = xtime(y3);
      if (!inv) begin
        t[127-8*(4*c)   -: 8] = x0 ^ x1 ^ a1 ^ a2 ^ a3;
        t[127-8*(4*c+1) -: 8] = a0 ^ x1 ^ x2 ^ a2 ^ a3;
        t[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ x2 ^ x3 ^ a3;
        t[127-8*(4*c+3) -: 8] = x0 ^ a0 ^ a1 ^ a2 ^ x3;
      end else begin
        // 14 = 8+4+2, 11 = 8+2+1, 13 = 8+4+1, 9 = 8+1
        t[127-8*(4*c)   -: 8] = (z0^y0^x0) ^ (z1^x1^a1) ^ (z2^y2^a2) ^ (z3^a3);
        t[127-8*(4*c+1) -: 8] = (z0^a0) ^ (z1^y1^x1) ^ (z2^x2^a2) ^ (z3^y3^a3);
        t[127-8*(4*c+2) -: 8] = (z0^y0^a0) ^ (z1^a1) ^ (z2^y2^x2) ^ (z3^x3^a3);
        t[127-8*(4*c+3) -: 8] = (z0^x0^a0) ^ (z1^y1^a1) ^ (z2^a2) ^ (z3^y3^x3^x3^x3);
      end
    end
    return t;
  endfunction

endpackage

>>> design/aes_ram.sv
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
module aes_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> design/aes_block_cipher_ecb_cbc.sv
// AES-128/192/256 block cipher in ECB or CBC mode.
// Depends on aes_pkg and aes_ram (round-key memory).
//
// Usage: write key words, IV, key size and chaining mode on the config
// port while idle. Blocks enter on the in channel (valid/ready) with the
// operation and a first-block flag; one result leaves per block on the
// out channel (valid/ready).
// The round keys live in a 60x32 RAM with a registered read. After any
// configuration write the next block first triggers a key expansion that
// writes one word per cycle (Nk words loaded from the key, then the remaining
// words, up to 60) with the previous word forwarded from a register.
// Encryption/decryption then runs one round at a time: the four round-key
// words are read in turn through the RAM port, then the round is applied.
// A result waits for the key expansion as well when keys are stale.
// One block is in work at a time; the block is accepted only when the core
// is idle, and the result sits in an output register, so a stalled receiver
// holds the result and the next block may already be taken and computed,
// waiting for that register to free. Reset clears the control state and
// configuration (CBC is the reset mode); datapath registers are not reset;
// the chain value resets to zero.
module aes_block_cipher_ecb_cbc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  input  logic        first_block_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o
);
  import aes_pkg::*;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StExp  = 5'b00010,
    StLoad = 5'b00100,
    StRnd  = 5'b01000,
    StDone = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [63:0] key_q [4];
  logic [63:0] iv_hi_q, iv_lo_q, chain_hi_q, chain_lo_q;
  logic [1:0]  ksize_q;
  logic        cbc_q, keys_ready_q;
  logic        op_q;
  logic [127:0] st_q;
  logic [127:32] kacc_q;
  logic [63:0] res_hi_q, res_lo_q;
  logic        out_valid_q;
  // Chain value in force when a block entered (used for decrypt).
  logic [63:0] chain_prev_hi_q, chain_prev_lo_q;
  // Expansion
  logic [RkAw-1:0] ei_q;
  logic [31:0]     prev_q;
  logic [7:0]      rc_q;
  logic [3:0]      nk_cnt_q;
  logic [RkAw-1:0] back_q;
  // Rounds
  logic [RndW-1:0] rnd_q;
  logic [2:0]      wcnt_q;
  logic            first_rnd_q;

  logic [RndW-1:0] nr;
  logic [3:0]      nk;
  logic [RkAw-1:0] total;
  always_comb begin
    unique case (ksize_q)
      Ksize192: begin nr = RndW'(12); nk = 4'd6; end
      Ksize256: begin nr = RndW'(14); nk = 4'd8; end
      default:  begin nr = RndW'(10); nk = 4'd4; end
    endcase
    total = RkAw'(4 * (32'(nr) + 1));
  end

  // RAM port usage.
  logic            ram_we;
  logic [RkAw-1:0] ram_waddr, ram_raddr;
  logic [31:0]     ram_wdata, ram_rdata;

  aes_ram #(.Width(32), .Depth(RkWords)) u_rk (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  // Expansion word computation: w[i] = w[i-nk] ^ f(w[i-1]); w[i-nk] comes
  // from the RAM read issued in the previous cycle.
  logic [31:0] key_word, exp_t, exp_w;
  logic [3:0]  imod;
  always_comb begin
    key_word = ei_q[0] ? key_q[ei_q[2:1]][31:0] : key_q[ei_q[2:1]][63:32];
    imod = nk_cnt_q;
    exp_t = prev_q;
    if (imod == 4'd0) exp_t = sub_word({prev_q[23:0], prev_q[31:24]}) ^ {rc_q, 24'h0};
    else if (nk == 4'd8 && imod == 4'd4) exp_t = sub_word(prev_q);
    exp_w = ram_rdata ^ exp_t;
  end

  logic exp_load;
  assign exp_load = (ei_q < RkAw'(nk));

  // Round key index: round r word c.
  logic [RndW-1:0] key_rnd;
  assign key_rnd = op_q ? RndW'(nr - rnd_q) : rnd_q;

  logic [RkAw-1:0] rd_addr_rnd;
  assign rd_addr_rnd = RkAw'(4 * 32'(key_rnd) + 32'(wcnt_q[1:0]));

  // Expansion read address: issue read of i-nk+1 for the next step.
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = ei_q;
    ram_wdata = exp_load ? key_word : exp_w;
    ram_raddr = rd_addr_rnd;
    if (state_q == StExp) begin
      ram_we = 1'b1;
      ram_raddr = back_q;
    end
  end

  logic acc_in, last_rnd;
  assign acc_in = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);
  assign last_rnd = (rnd_q == nr);

  logic [127:0] blk_in, rk, rnd_out, pre;
  logic [63:0]  ch_hi, ch_lo;
  always_comb begin
    ch_hi = first_block_i ? iv_hi_q : chain_hi_q;
    ch_lo = first_block_i ? iv_lo_q : chain_lo_q;
    blk_in = {block_high_i, block_low_i};
    if (!operation_i && cbc_q) blk_in = blk_in ^ {ch_hi, ch_lo};
    // The last key word is taken straight from the RAM in the apply cycle.
    rk = {kacc_q[127:32], ram_rdata};
    rnd_out = st_q ^ rk;
    if (!first_rnd_q) begin
      if (!op_q) begin
        pre = sub_shift(st_q, 1'b0);
        if (!last_rnd) pre = mix(pre, 1'b0);
        rnd_out = pre ^ rk;
      end else begin
        pre = sub_shift(st_q, 1'b1) ^ rk;
        rnd_out = last_rnd ? pre : mix(pre, 1'b1);
      end
    end else begin
      pre = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (acc_in) state_d = keys_ready_q ? StLoad : StExp;
      StExp:  if (ei_q == total - RkAw'(1)) state_d = StLoad;
      StLoad: state_d = StRnd;
      StRnd:  if (wcnt_q == 3'd4 && last_rnd) state_d = StDone;
      StDone: if (!out_valid_q || out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      iv_hi_q <= '0; iv_lo_q <= '0; chain_hi_q <= '0; chain_lo_q <= '0;
      ksize_q <= '0; cbc_q <= 1'b1; keys_ready_q <= 1'b0;
      out_valid_q <= 1'b0;
      ei_q <= '0; nk_cnt_q <= '0; back_q <= '0; rc_q <= 8'h01; prev_q <= '0;
      rnd_q <= '0; wcnt_q <= '0; first_rnd_q <= 1'b0; op_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        keys_ready_q <= 1'b0;
        unique case (cfg_index_i)
          CfgKey0:  key_q[0] <= cfg_data_i;
          CfgKey1:  key_q[1] <= cfg_data_i;
          CfgKey2:  key_q[2] <= cfg_data_i;
          CfgKey3:  key_q[3] <= cfg_data_i;
          CfgIvHi:  iv_hi_q <= cfg_data_i;
          CfgIvLo:  iv_lo_q <= cfg_data_i;
          CfgKsize: ksize_q <= cfg_data_i[1:0];
          CfgChain: cbc_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (acc_in) begin
        op_q <= operation_i;
        ei_q <= '0; nk_cnt_q <= '0; rc_q <= 8'h01;
        back_q <= RkAw'(1) - RkAw'(nk) + RkAw'(nk) - RkAw'(1); // word 0
        rnd_q <= '0; wcnt_q <= '0; first_rnd_q <= 1'b1;
        if (first_block_i) begin
          chain_hi_q <= iv_hi_q; chain_lo_q <= iv_lo_q;
        end
        if (operation_i && cbc_q) begin
          chain_hi_q <= block_high_i; chain_lo_q <= block_low_i;
        end
      end
      if (state_q == StExp) begin
        ei_q <= ei_q + RkAw'(1);
        prev_q <= ram_wdata;
        // back_q tracks (i+1) - nk for the next word's read.
        back_q <= (ei_q + RkAw'(2) >= RkAw'(nk)) ? RkAw'(ei_q + RkAw'(2) - RkAw'(nk)) : '0;
        if (!exp_load) begin
          if (imod == 4'd0) rc_q <= xtime(rc_q);
        end
        nk_cnt_q <= (ei_q + RkAw'(1) >= RkAw'(nk))
                    ? ((nk_cnt_q + 4'd1 == nk || exp_load) ? 4'd0 : nk_cnt_q + 4'd1)
                    : 4'd0;
        if (state_d == StLoad) keys_ready_q <= 1'b1;
      end
      if (state_q == StLoad) wcnt_q <= 3'd1;
      if (state_q == StRnd) begin
        if (wcnt_q == 3'd4) begin
          wcnt_q <= 3'd0;
          first_rnd_q <= 1'b0;
          rnd_q <= rnd_q + RndW'(1);
        end else begin
          wcnt_q <= wcnt_q + 3'd1;
        end
      end
      if (state_q == StDone && state_d == StIdle) begin
        out_valid_q <= 1'b1;
        if (!op_q && cbc_q) begin
          chain_hi_q <= st_q[127:64]; chain_lo_q <= st_q[63:0];
        end
      end
    end
  end

  // Datapath registers (no reset needed).
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      st_q <= blk_in;
    end
    // Words of the round key arrive in the cycle after their read.
    if (state_q == StRnd && wcnt_q != 3'd0 && wcnt_q != 3'd4) begin
      kacc_q[127-32*(32'(wcnt_q)-1) -: 32] <= ram_rdata;
    end
    if (state_q == StRnd && wcnt_q == 3'd4) st_q <= rnd_out;
    if (state_q == StDone && state_d == StIdle) begin
      if (op_q && cbc_q) begin
        res_hi_q <= st_q[127:64] ^ chain_prev_hi_q;
        res_lo_q <= st_q[63:0] ^ chain_prev_lo_q;
      end else begin
        res_hi_q <= st_q[127:64];
        res_lo_q <= st_q[63:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      chain_prev_hi_q <= ch_hi;
      chain_prev_lo_q <= ch_lo;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_high_o = res_hi_q;
  assign result_low_o  = res_lo_q;

  // The round counter never passes the round count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRnd |-> rnd_q <= nr) else $error("round overrun");
  // A waiting result stays valid until the receiver is ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q) else $error("result lost");
  // No block is taken outside idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_in |-> state_q == StIdle) else $error("accept while busy");
endmodule

>>> tb/sv/aes_block_cipher_ecb_cbc_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for aes_block_cipher_ecb_cbc: AES ECB/CBC blocks are
// predicted in the bench and compared with each result. Depends on aes_pkg.
module aes_block_cipher_ecb_cbc_tb;
  import aes_pkg::*;

  localparam logic       OpEncrypt  = 1'b0;
  localparam logic       OpDecrypt  = 1'b1;
  localparam logic [1:0] Ksize128   = 2'd0;
  localparam logic [1:0] KsizeAlias = 2'd3;
  localparam logic       ModeEcb    = 1'b0;
  localparam logic       ModeCbc    = 1'b1;
  localparam int         IdleLimit  = 2000;
  localparam int         ItemGoal   = 1800;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } out_block_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = CfgKey0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        operation_i = OpEncrypt;
  logic [63:0] block_high_i = '0;
  logic [63:0] block_low_i = '0;
  logic        first_block_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] result_high_o;
  logic [63:0] result_low_o;

  aes_block_cipher_ecb_cbc dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Cipher state mirrored in the bench.
  byte_t       fwd_tab [256];
  byte_t       inv_tab [256];
  logic [63:0] key_words [4];
  logic [63:0] iv_words [2];
  logic [1:0]  key_len;
  logic        cbc_on;
  logic [31:0] sched [RkWords];
  logic        sched_valid;
  logic [63:0] chain_val [2];

  out_block_t expected_blocks [$];
  int         mismatches;
  int         items_sent;
  int         burst_left;
  bit         gaps_on;
  int         idle_cycles;
  int         stall_left;
  int unsigned cyc;

  function automatic byte_t dbl(byte_t b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t gf_mul(byte_t a, byte_t b);
    byte_t p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = dbl(a);
    end
    return p;
  endfunction

  // S-box from the GF(2^8) inverse and the affine map.
  task automatic build_boxes();
    byte_t p, s;
    for (int i = 0; i < 256; i++) begin
      p = 8'h01;
      repeat (254) p = gf_mul(p, byte_t'(i));
      s = p ^ {p[6:0], p[7]} ^ {p[5:0], p[7:6]} ^ {p[4:0], p[7:5]} ^ {p[3:0], p[7:4]} ^ 8'h63;
      fwd_tab[i] = s;
      inv_tab[s] = byte_t'(i);
    end
  endtask

  function automatic int rounds_for_size();
    return (key_len == Ksize192) ? 12 : (key_len == Ksize256) ? 14 : 10;
  endfunction

  function automatic logic [31:0] sbox_word(logic [31:0] w);
    return {fwd_tab[w[31:24]], fwd_tab[w[23:16]], fwd_tab[w[15:8]], fwd_tab[w[7:0]]};
  endfunction

  task automatic expand_schedule();
    int nk, total;
    logic [31:0] t;
    byte_t rc;
    nk = (key_len == Ksize192) ? 6 : (key_len == Ksize256) ? 8 : 4;
    total = 4 * (rounds_for_size() + 1);
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      sched[i] = i[0] ? key_words[i >> 1][31:0] : key_words[i >> 1][63:32];
    for (int i = nk; i < total; i++) begin
      t = sched[i-1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = dbl(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sbox_word(t);
      end
      sched[i] = sched[i-nk] ^ t;
    end
    sched_valid = 1'b1;
  endtask

  // Byte k of the state (k = 4*column + row) sits at bits 127-8k.
  function automatic blk_t add_key(blk_t s, int r);
    for (int c = 0; c < 4; c++) s[127-32*c -: 32] ^= sched[4*r + c];
    return s;
  endfunction

  function automatic blk_t subst_shift(blk_t s, logic inv);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) t[127-8*(4*((c+r)%4)+r) -: 8] = inv_tab[s[127-8*(4*c+r) -: 8]];
        else     t[127-8*(4*c+r) -: 8] = fwd_tab[s[127-8*(4*((c+r)%4)+r) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic byte_t mix_coef(logic inv, int idx);
    case (idx)
      0: return inv ? 8'd14 : 8'd2;
      1: return inv ? 8'd11 : 8'd3;
      2: return inv ? 8'd13 : 8'd1;
      default: return inv ? 8'd9 : 8'd1;
    endcase
  endfunction

  function automatic blk_t mix_columns(blk_t s, logic inv);
    blk_t t;
    byte_t acc;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++)
          acc ^= gf_mul(s[127-8*(4*c+k) -: 8], mix_coef(inv, (k + 4 - r) % 4));
        t[127-8*(4*c+r) -: 8] = acc;
      end
    end
    return t;
  endfunction

  function automatic blk_t aes_forward(blk_t s);
    int nr;
    nr = rounds_for_size();
    s = add_key(s, 0);
    for (int r = 1; r <= nr; r++) begin
      s = subst_shift(s, 1'b0);
      if (r != nr) s = mix_columns(s, 1'b0);
      s = add_key(s, r);
    end
    return s;
  endfunction

  function automatic blk_t aes_inverse(blk_t s);
    int nr;
    nr = rounds_for_size();
    s = add_key(s, nr);
    for (int r = nr; r > 0; r--) begin
      s = subst_shift(s, 1'b1);
      s = add_key(s, r - 1);
      if (r != 1) s = mix_columns(s, 1'b1);
    end
    return s;
  endfunction

  task automatic predict_block(logic op, logic [63:0] hi, logic [63:0] lo, logic first);
    blk_t s;
    if (!sched_valid) expand_schedule();
    if (first) begin
      chain_val[0] = iv_words[0];
      chain_val[1] = iv_words[1];
    end
    if (op == OpEncrypt) begin
      s = {hi, lo};
      if (cbc_on) s ^= {chain_val[0], chain_val[1]};
      s = aes_forward(s);
      if (cbc_on) {chain_val[0], chain_val[1]} = s;
    end else begin
      s = aes_inverse({hi, lo});
      if (cbc_on) begin
        s ^= {chain_val[0], chain_val[1]};
        chain_val[0] = hi;
        chain_val[1] = lo;
      end
    end
    expected_blocks.push_back(out_block_t'(s));
  endtask

  // Leaves the write enable high; the caller lowers it after its last write.
  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CfgKey0:  key_words[0] = data;
      CfgKey1:  key_words[1] = data;
      CfgKey2:  key_words[2] = data;
      CfgKey3:  key_words[3] = data;
      CfgIvHi:  iv_words[0] = data;
      CfgIvLo:  iv_words[1] = data;
      CfgKsize: key_len = data[1:0];
      default:  cbc_on = data[0];
    endcase
    sched_valid = 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_one(logic [2:0] idx, logic [63:0] data);
    write_reg(idx, data);
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_cipher(logic [63:0] k0, k1, k2, k3, ivh, ivl,
                                logic [1:0] ks, logic cm);
    write_reg(CfgKey0, k0);
    write_reg(CfgKey1, k1);
    write_reg(CfgKey2, k2);
    write_reg(CfgKey3, k3);
    write_reg(CfgIvHi, ivh);
    write_reg(CfgIvLo, ivl);
    write_reg(CfgKsize, {62'd0, ks});
    write_reg(CfgChain, {63'd0, cm});
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_block(logic op, logic [63:0] hi, logic [63:0] lo, logic first);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        in_valid_i <= 1'b0;
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5))
          @(posedge clk_i);
      end
      burst_left--;
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    block_high_i <= hi;
    block_low_i <= lo;
    first_block_i <= first;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_block(op, hi, lo, first);
    items_sent++;
  endtask

  // Every block yields a result, so an empty queue means the core is idle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 64'h0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic test_reset_defaults();
    // CBC with an all-zero key and a chain value that was never started.
    send_block(OpEncrypt, 64'h0, 64'h0, 1'b0);
    send_block(OpDecrypt, '1, '1, 1'b0);
    drain();
  endtask

  task automatic test_key_sizes();
    program_cipher(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
                   64'h18191a1b1c1d1e1f, 64'h0, 64'h0, Ksize128, ModeEcb);
    send_block(OpEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    send_block(OpDecrypt, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b0);
    send_block(OpEncrypt, '1, '1, 1'b0);
    drain();
    write_one(CfgKsize, {62'd0, Ksize192});
    send_block(OpEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    send_block(OpDecrypt, 64'h0, 64'h0, 1'b0);
    drain();
    write_one(CfgKsize, {62'd0, Ksize256});
    send_block(OpEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    send_block(OpDecrypt, '1, 64'h0, 1'b0);
    drain();
    // The unused size code falls back to a 128-bit key.
    write_one(CfgKsize, {62'd0, KsizeAlias});
    send_block(OpEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    drain();
  endtask

  task automatic test_chaining();
    program_cipher('1, '1, '1, '1, 64'h0f0e0d0c0b0a0908, 64'h0706050403020100,
                   Ksize256, ModeCbc);
    send_block(OpEncrypt, 64'h1, 64'h2, 1'b1);
    send_block(OpEncrypt, 64'h3, 64'h4, 1'b0);
    send_block(OpDecrypt, '1, 64'h5, 1'b1);
    send_block(OpDecrypt, 64'h6, '1, 1'b0);
    drain();
    // A write mid-message must leave the chain value alone.
    write_one(CfgIvLo, '1);
    send_block(OpEncrypt, 64'h7, 64'h8, 1'b0);
    drain();
    // In ECB the first-block flag still reloads the chain value from the IV.
    write_one(CfgChain, {63'd0, ModeEcb});
    send_block(OpEncrypt, 64'h9, 64'ha, 1'b1);
    drain();
    write_one(CfgChain, {63'd0, ModeCbc});
    send_block(OpEncrypt, 64'hb, 64'hc, 1'b0);
    drain();
  endtask

  task automatic test_random_messages();
    int len;
    logic op;
    gaps_on = 1'b1;
    while (items_sent < ItemGoal) begin
      drain();
      program_cipher(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                     rand_word(), 2'($urandom_range(0, 3)),
                     ($urandom_range(0, 3) != 0) ? ModeCbc : ModeEcb);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(20, 80)) begin
        len = $urandom_range(1, 8);
        op = 1'($urandom);
        for (int i = 0; i < len && items_sent < ItemGoal; i++) begin
          // Mostly clean messages, with some mixed operations and restarts.
          send_block(($urandom_range(0, 7) == 0) ? ~op : op, rand_word(), rand_word(),
                     (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0));
        end
        if ($urandom_range(0, 15) == 0) drain();
      end
    end
    drain();
  endtask

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (!cyc[11] && $urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 25);
    end
  end

  always @(posedge clk_i) begin
    out_block_t exp_blk;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result transaction %h %h", result_high_o, result_low_o);
      end else begin
        exp_blk = expected_blocks.pop_front();
        if (result_high_o !== exp_blk.hi || result_low_o !== exp_blk.lo) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %h %h, got %h %h",
                     exp_blk.hi, exp_blk.lo, result_high_o, result_low_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    key_words = '{default: 64'h0};
    iv_words = '{default: 64'h0};
    chain_val = '{default: 64'h0};
    key_len = Ksize128;
    cbc_on = ModeCbc;
    sched_valid = 1'b0;
    mismatches = 0;
    items_sent = 0;
    burst_left = 0;
    gaps_on = 1'b0;
    idle_cycles = 0;
    stall_left = 0;
    cyc = 0;
    build_boxes();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_key_sizes();
    test_chaining();
    test_random_messages();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_blocks.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
